### rtl/overwriting_ring_buffer_seq_index_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the overwriting ring buffer unit
// Clocked property checks on clk; one form gated by reset, one not.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_RING_BUFFER_SEQ_INDEX_UNIT_ASSERT_SVH
`define OVERWRITING_RING_BUFFER_SEQ_INDEX_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define ORBSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ORBSI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ORBSI_ASSERT(lbl, prop, msg)
`define ORBSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/orbsi_pkg.sv
// ----------------------------------------------------------------------------
// orbsi_pkg
// Types and constants shared by the overwriting ring buffer unit.
// ----------------------------------------------------------------------------
package orbsi_pkg;

	localparam int MAX_SLOTS   = 1024;
	localparam int RECORD_BITS = 64;
	localparam int DATA_W      = 64;
	localparam int SEQ_W       = 32;
	localparam int CAP_W       = 11;
	localparam int SLOT_W      = $clog2(MAX_SLOTS);
	localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
	localparam int REQ_W       = 3;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH     = 3'd0,
		REQ_READ_ABS = 3'd1,
		REQ_REPLACE  = 3'd2,
		REQ_READ_REL = 3'd3,
		REQ_CLEAR    = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_READ
	} cmd_op_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [SEQ_W-1:0]  index;
		logic [DATA_W-1:0] record_data;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SEQ_W-1:0]  assigned_index;
		logic              evicted;
		logic [SEQ_W-1:0]  evict_seq;
		logic              retained;
		logic [DATA_W-1:0] read_data;
		logic [CNT_W-1:0]  fill_count;
		logic [SEQ_W-1:0]  total_pushed;
		logic [SEQ_W-1:0]  first_held;
	} rsp_t;

	typedef struct packed {
		cmd_op_t                op;
		logic [SLOT_W-1:0]      slot;
		logic [RECORD_BITS-1:0] wdata;
		rsp_t                   stat;
	} cmd_t;

endpackage

### rtl/orbsi_req_if.sv
// ----------------------------------------------------------------------------
// orbsi_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface orbsi_req_if import orbsi_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/orbsi_rsp_if.sv
// ----------------------------------------------------------------------------
// orbsi_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface orbsi_rsp_if import orbsi_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/orbsi_ram.sv
// ----------------------------------------------------------------------------
// orbsi_ram
// Single-port RAM with registered read; read data holds while not enabled.
// ----------------------------------------------------------------------------
module orbsi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### rtl/orbsi_front.sv
// ----------------------------------------------------------------------------
// orbsi_front
// Accepts requests, runs the ring counters and turns each word into a slot
// command with its status fields.
// ----------------------------------------------------------------------------
`include "overwriting_ring_buffer_seq_index_unit_assert.svh"

module orbsi_front import orbsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	orbsi_req_if.sink        req,
	input  logic             q_full,
	output logic             q_push,
	output cmd_t             q_din
);

	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  held_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [SEQ_W-1:0]  total_q;
	logic [SEQ_W-1:0]  first_q;

	logic [CNT_W-1:0]  held_n;
	logic [SLOT_W-1:0] oldest_n;
	logic [SEQ_W-1:0]  total_n;
	logic [SEQ_W-1:0]  first_n;

	logic [SEQ_W-1:0]  off_abs;
	logic              hit_abs;
	logic              hit_rel;
	logic              is_full;
	logic              keep;
	logic [CNT_W-1:0]  off_cnt;
	logic [CNT_W:0]    slot_sum;
	logic [CNT_W:0]    slot_wrap;
	logic [SLOT_W-1:0] slot_calc;
	logic [CNT_W-1:0]  oldest_inc;
	logic [SLOT_W-1:0] oldest_adv;
	logic [CNT_W-1:0]  cap_sat;

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	assign off_abs = req.data.index - first_q;
	assign hit_abs = off_abs < SEQ_W'(held_q);
	assign hit_rel = req.data.index < SEQ_W'(held_q);
	assign is_full = held_q >= cap_q;
	assign keep    = cap_q != '0;

	always_comb begin
		case (req.data.req_type)
			REQ_PUSH:     off_cnt = held_q;
			REQ_READ_REL: off_cnt = req.data.index[CNT_W-1:0];
			default:      off_cnt = off_abs[CNT_W-1:0];
		endcase
	end

	// for every slot that is used the offset stays below the capacity, so one subtract wraps it
	assign slot_sum  = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(off_cnt);
	assign slot_wrap = (slot_sum >= (CNT_W+1)'(cap_q)) ? slot_sum - (CNT_W+1)'(cap_q) : slot_sum;
	assign slot_calc = slot_wrap[SLOT_W-1:0];

	assign oldest_inc = CNT_W'(oldest_q) + CNT_W'(1);
	assign oldest_adv = (oldest_inc == cap_q) ? '0 : oldest_inc[SLOT_W-1:0];

	assign cap_sat = (cfg_wdata > CAP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(cfg_wdata);

	always_comb begin
		held_n   = held_q;
		oldest_n = oldest_q;
		total_n  = total_q;
		first_n  = first_q;
		q_din    = '0;
		q_din.op    = CMD_NONE;
		q_din.slot  = slot_calc;
		q_din.wdata = req.data.record_data[RECORD_BITS-1:0];
		case (req.data.req_type)
			REQ_PUSH: begin
				q_din.stat.assigned_index = total_q;
				total_n = total_q + SEQ_W'(1);
				if (keep) begin
					q_din.stat.retained = 1'b1;
					q_din.op = CMD_WRITE;
					if (is_full) begin
						q_din.stat.evicted   = 1'b1;
						q_din.stat.evict_seq = first_q;
						q_din.slot = oldest_q;
						oldest_n   = oldest_adv;
						first_n    = first_q + SEQ_W'(1);
					end else begin
						held_n = held_q + CNT_W'(1);
					end
				end else begin
					first_n = first_q + SEQ_W'(1);
				end
			end
			REQ_READ_ABS: begin
				if (hit_abs) begin
					q_din.stat.hit = 1'b1;
					q_din.op = CMD_READ;
				end
			end
			REQ_REPLACE: begin
				if (hit_abs) begin
					q_din.stat.hit = 1'b1;
					q_din.op = CMD_WRITE;
				end
			end
			REQ_READ_REL: begin
				if (hit_rel) begin
					q_din.stat.hit = 1'b1;
					q_din.op = CMD_READ;
				end
			end
			REQ_CLEAR: begin
				held_n   = '0;
				oldest_n = '0;
				total_n  = '0;
				first_n  = '0;
			end
			default: begin
			end
		endcase
		q_din.stat.fill_count   = held_n;
		q_din.stat.total_pushed = total_n;
		q_din.stat.first_held   = first_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CNT_W'(MAX_SLOTS);
			held_q   <= '0;
			oldest_q <= '0;
			total_q  <= '0;
			first_q  <= '0;
		end else if (cfg_we) begin
			cap_q    <= cap_sat;
			held_q   <= '0;
			oldest_q <= '0;
			total_q  <= '0;
			first_q  <= '0;
		end else if (q_push) begin
			held_q   <= held_n;
			oldest_q <= oldest_n;
			total_q  <= total_n;
			first_q  <= first_n;
		end
	end

	`ORBSI_ASSERT(a_held_within_cap, held_q <= cap_q, "fill count above capacity")
	`ORBSI_ASSERT(a_seq_consistent, (first_q + SEQ_W'(held_q)) == total_q,
		"first held plus fill count differs from total pushed")
	`ORBSI_ASSERT(a_oldest_in_ring,
		(cap_q == '0) ? (oldest_q == '0) : (CNT_W'(oldest_q) < cap_q),
		"oldest slot outside the ring")

endmodule

### rtl/orbsi_queue.sv
// ----------------------------------------------------------------------------
// orbsi_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`include "overwriting_ring_buffer_seq_index_unit_assert.svh"

module orbsi_queue import orbsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ORBSI_ASSERT(a_no_overflow, push |-> !full, "command pushed into full queue")
	`ORBSI_ASSERT(a_no_underflow, pop |-> !empty, "command popped from empty queue")

endmodule

### rtl/orbsi_back.sv
// ----------------------------------------------------------------------------
// orbsi_back
// Executes slot commands on the record RAM and registers the result word.
// ----------------------------------------------------------------------------
module orbsi_back import orbsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_dout,
	output logic       q_pop,
	orbsi_rsp_if.source rsp
);

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	logic                   out_valid_q;
	rsp_t                   out_q;
	rsp_t                   out_d;
	logic                   adv;
	logic [RECORD_BITS-1:0] ram_rdata;

	assign adv   = valid_s1 && (!out_valid_q || rsp.ready);
	assign q_pop = !q_empty && (!valid_s1 || adv);

	orbsi_ram #(
		.WIDTH(RECORD_BITS),
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk  (clk),
		.en   (q_pop && (q_dout.op != CMD_NONE)),
		.we   (q_dout.op == CMD_WRITE),
		.addr (q_dout.slot),
		.wdata(q_dout.wdata),
		.rdata(ram_rdata)
	);

	always_comb begin
		out_d = cmd_s1.stat;
		out_d.read_data = (cmd_s1.op == CMD_READ) ? DATA_W'(ram_rdata) : '0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_dout;
		end
		if (adv) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

### rtl/overwriting_ring_buffer_seq_index_unit.sv
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_seq_index_unit
// Overwriting ring store of records addressed by absolute sequence number.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    req_type, index, record_data
//   rsp      out  valid/ready    hit .. first_held status
//   cfg      in   cfg_we         capacity (saturates at MAX_SLOTS)
//
// Sustained rate one word per cycle while rsp.ready holds, set by the single
// RAM port: each word makes at most one slot access. Reset clears the
// counters only; record contents are unknown until written, no clearing
// pass. Words pass a two-entry queue, an issue stage and an output register,
// which absorb stalls on the result side before req.ready drops.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_seq_index_unit import orbsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	orbsi_req_if.sink        req,
	orbsi_rsp_if.source      rsp
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_din;
	cmd_t q_dout;

	orbsi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_din    (q_din)
	);

	orbsi_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	orbsi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_dout (q_dout),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);

endmodule
